// ----- rtl/core/uart_rb_pkg.sv -----
// ----------------------------------------------------------------------------
// UART ring buffer package
// Shared types, constants and helpers for the receive and send rings.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

    localparam int RX_DEPTH = 64;
    localparam int TX_DEPTH = 64;
    localparam int RX_PTR_W = $clog2(RX_DEPTH);
    localparam int TX_PTR_W = $clog2(TX_DEPTH);
    localparam int BYTE_W   = 8;

    typedef logic [RX_PTR_W-1:0] uart_rb_rx_ptr_t;
    typedef logic [TX_PTR_W-1:0] uart_rb_tx_ptr_t;

    typedef enum logic [1:0] {
        OP_HOST_READ  = 2'd0,
        OP_HOST_WRITE = 2'd1,
        OP_LINE_RX    = 2'd2,
        OP_TX_READY   = 2'd3
    } uart_rb_op_t;

    typedef struct packed {
        uart_rb_op_t       opcode;
        logic [BYTE_W-1:0] data_byte;
        logic              tx_ready_flag;
    } uart_rb_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic [BYTE_W-1:0] line_byte;
        logic              line_send;
        logic              tx_irq_enable;
        logic              byte_dropped;
    } uart_rb_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEND
    } uart_rb_state_t;

    typedef struct packed {
        logic accept;
        logic load;
    } uart_rb_cmd_t;

    function automatic uart_rb_rx_ptr_t rx_next_index(input uart_rb_rx_ptr_t p);
        if (p == RX_PTR_W'(RX_DEPTH - 1)) begin
            return '0;
        end
        return p + RX_PTR_W'(1);
    endfunction

    function automatic uart_rb_tx_ptr_t tx_next_index(input uart_rb_tx_ptr_t p);
        if (p == TX_PTR_W'(TX_DEPTH - 1)) begin
            return '0;
        end
        return p + TX_PTR_W'(1);
    endfunction

endpackage

// ----- rtl/core/uart_rb_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module uart_rb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/uart_rb_ctrl.sv -----
// ----------------------------------------------------------------------------
// UART ring buffer controller
// Sequences one word through accept, memory read and result hand-off.
// ----------------------------------------------------------------------------
module uart_rb_ctrl
    import uart_rb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    output uart_rb_cmd_t cmd
);

    uart_rb_state_t state_reg;
    uart_rb_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/uart_rb_datapath.sv -----
// ----------------------------------------------------------------------------
// UART ring buffer datapath
// Ring pointers, interrupt enable, both ring memories and the result register.
// ----------------------------------------------------------------------------
module uart_rb_datapath
    import uart_rb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  uart_rb_cmd_t cmd,
    input  uart_rb_in_t  s_data,
    output uart_rb_out_t m_data
);

    uart_rb_rx_ptr_t   rx_rd_reg, rx_rd_next;
    uart_rb_rx_ptr_t   rx_wr_reg, rx_wr_next;
    uart_rb_tx_ptr_t   tx_rd_reg, tx_rd_next;
    uart_rb_tx_ptr_t   tx_wr_reg, tx_wr_next;
    logic              irq_reg, irq_next;
    logic              rx_pend_reg, rx_pend_next;
    logic              tx_pend_reg, tx_pend_next;
    uart_rb_out_t      res_reg, res_next;
    logic              rx_we, tx_we;
    logic [BYTE_W-1:0] rx_rdata, tx_rdata;
    uart_rb_rx_ptr_t   rx_wr_inc, rx_rd_inc;
    uart_rb_tx_ptr_t   tx_wr_inc, tx_rd_inc;
    logic              rx_empty, tx_empty;

    assign rx_wr_inc = rx_next_index(rx_wr_reg);
    assign rx_rd_inc = rx_next_index(rx_rd_reg);
    assign tx_wr_inc = tx_next_index(tx_wr_reg);
    assign tx_rd_inc = tx_next_index(tx_rd_reg);
    assign rx_empty  = (rx_rd_reg == rx_wr_reg);
    assign tx_empty  = (tx_rd_reg == tx_wr_reg);

    uart_rb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_wr_reg),
        .wdata (s_data.data_byte),
        .raddr (rx_rd_reg),
        .rdata (rx_rdata)
    );

    uart_rb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_wr_reg),
        .wdata (s_data.data_byte),
        .raddr (tx_rd_reg),
        .rdata (tx_rdata)
    );

    always_comb begin
        rx_rd_next   = rx_rd_reg;
        rx_wr_next   = rx_wr_reg;
        tx_rd_next   = tx_rd_reg;
        tx_wr_next   = tx_wr_reg;
        irq_next     = irq_reg;
        rx_pend_next = rx_pend_reg;
        tx_pend_next = tx_pend_reg;
        res_next     = res_reg;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        if (cmd.accept) begin
            res_next     = '0;
            rx_pend_next = 1'b0;
            tx_pend_next = 1'b0;
            unique case (s_data.opcode)
                OP_HOST_READ: begin
                    if (!rx_empty) begin
                        rx_pend_next = 1'b1;
                        rx_rd_next   = rx_rd_inc;
                    end else begin
                        rx_rd_next = '0;
                        rx_wr_next = '0;
                    end
                end
                OP_HOST_WRITE: begin
                    if (tx_empty && s_data.tx_ready_flag) begin
                        res_next.line_byte = s_data.data_byte;
                        res_next.line_send = 1'b1;
                    end else if (tx_wr_inc != tx_rd_reg) begin
                        tx_we      = 1'b1;
                        tx_wr_next = tx_wr_inc;
                    end else begin
                        res_next.byte_dropped = 1'b1;
                    end
                    irq_next = 1'b1;
                end
                OP_LINE_RX: begin
                    if (rx_wr_inc != rx_rd_reg) begin
                        rx_we      = 1'b1;
                        rx_wr_next = rx_wr_inc;
                    end else begin
                        res_next.byte_dropped = 1'b1;
                    end
                end
                OP_TX_READY: begin
                    if (!tx_empty) begin
                        tx_pend_next       = 1'b1;
                        res_next.line_send = 1'b1;
                        tx_rd_next         = tx_rd_inc;
                    end
                    if (tx_empty || (tx_rd_inc == tx_wr_reg)) begin
                        tx_rd_next = '0;
                        tx_wr_next = '0;
                        irq_next   = 1'b0;
                    end
                end
                default: begin
                    res_next = '0;
                end
            endcase
            res_next.tx_irq_enable = irq_next;
        end
        if (cmd.load) begin
            if (rx_pend_reg) begin
                res_next.read_byte = rx_rdata;
            end
            if (tx_pend_reg) begin
                res_next.line_byte = tx_rdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_rd_reg   <= '0;
            rx_wr_reg   <= '0;
            tx_rd_reg   <= '0;
            tx_wr_reg   <= '0;
            irq_reg     <= 1'b0;
            rx_pend_reg <= 1'b0;
            tx_pend_reg <= 1'b0;
        end else begin
            rx_rd_reg   <= rx_rd_next;
            rx_wr_reg   <= rx_wr_next;
            tx_rd_reg   <= tx_rd_next;
            tx_wr_reg   <= tx_wr_next;
            irq_reg     <= irq_next;
            rx_pend_reg <= rx_pend_next;
            tx_pend_reg <= tx_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_data = res_reg;

endmodule

// ----- rtl/core/uart_rx_tx_ring_buffers.sv -----
// Sequence: an accepted word takes the controller to ST_LOAD, where the
// registered ring memory read enters the result register, then to ST_SEND,
// where the result word is held until taken. No new word is accepted meanwhile.
// Reset: aresetn is synchronous and active low; it clears the ring pointers,
// the transmit interrupt enable and the controller. Ring contents are not cleared.
// ----------------------------------------------------------------------------
// UART receive and send ring buffers
// Host and line events on a receive ring and a send ring, one result per word.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers
    import uart_rb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  uart_rb_in_t  s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output uart_rb_out_t m_data
);

    uart_rb_cmd_t cmd;

    uart_rb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    uart_rb_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while a result word is pending");

    a_result_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> ##2 m_valid)
        else $error("result word not presented two cycles after accept");

    a_idle_line_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.line_send) |-> (m_data.line_byte == '0))
        else $error("line byte non-zero without a send");

    a_drop_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.byte_dropped) |-> (!m_data.line_send && m_data.read_byte == '0))
        else $error("dropped word also reports a transfer");
`endif

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// UART ring buffer testbench
// Drives host reads, host writes, line receives and transmitter-ready events
// into both rings, and compares each result word with its directed row's
// expected word or a cycle-free ring model. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import uart_rb_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;

    typedef enum int {
        TR_MIX,
        TR_RX_FILL,
        TR_RX_DRAIN,
        TR_TX_FILL,
        TR_TX_DRAIN
    } traffic_t;

    typedef struct packed {
        uart_rb_op_t       opcode;
        logic [BYTE_W-1:0] data_byte;
        logic              tx_ready_flag;
        logic              typed;
        uart_rb_out_t      result;
    } stim_row_t;

    logic         aclk    = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    uart_rb_in_t  s_data  = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    uart_rb_out_t m_data;

    logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
    logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
    uart_rb_rx_ptr_t   rx_rd = '0;
    uart_rb_rx_ptr_t   rx_wr = '0;
    uart_rb_tx_ptr_t   tx_rd = '0;
    uart_rb_tx_ptr_t   tx_wr = '0;
    logic              irq_en = 1'b0;

    uart_rb_out_t pending_results [$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count    = 0;
    int unsigned  results_seen   = 0;
    int unsigned  send_gap_max   = 3;
    int unsigned  recv_gap_max   = 3;

    stim_row_t directed_rows [24] = '{
        '{OP_HOST_READ,  8'h00, 1'b0, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{OP_TX_READY,   8'h00, 1'b1, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{OP_HOST_WRITE, 8'hFF, 1'b1, 1'b1, '{8'h00, 8'hFF, 1'b1, 1'b1, 1'b0}},
        '{OP_HOST_WRITE, 8'h00, 1'b0, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 1'b0}},
        '{OP_HOST_WRITE, 8'h80, 1'b1, 1'b0, '0},
        '{OP_HOST_WRITE, 8'h7F, 1'b0, 1'b0, '0},
        '{OP_TX_READY,   8'h55, 1'b0, 1'b0, '0},
        '{OP_TX_READY,   8'hAA, 1'b1, 1'b0, '0},
        '{OP_TX_READY,   8'h00, 1'b0, 1'b0, '0},
        '{OP_TX_READY,   8'hFF, 1'b1, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{OP_LINE_RX,    8'hFF, 1'b1, 1'b0, '0},
        '{OP_LINE_RX,    8'h00, 1'b0, 1'b0, '0},
        '{OP_LINE_RX,    8'h80, 1'b1, 1'b0, '0},
        '{OP_LINE_RX,    8'h7F, 1'b0, 1'b0, '0},
        '{OP_HOST_READ,  8'hAA, 1'b1, 1'b0, '0},
        '{OP_HOST_READ,  8'h55, 1'b0, 1'b0, '0},
        '{OP_HOST_READ,  8'h00, 1'b1, 1'b0, '0},
        '{OP_HOST_READ,  8'h00, 1'b0, 1'b0, '0},
        '{OP_HOST_READ,  8'hFF, 1'b1, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{OP_HOST_WRITE, 8'h01, 1'b1, 1'b1, '{8'h00, 8'h01, 1'b1, 1'b1, 1'b0}},
        '{OP_HOST_READ,  8'h00, 1'b0, 1'b0, '0},
        '{OP_LINE_RX,    8'h3C, 1'b1, 1'b0, '0},
        '{OP_TX_READY,   8'h00, 1'b0, 1'b0, '0},
        '{OP_HOST_READ,  8'h00, 1'b1, 1'b0, '0}
    };

    uart_rx_tx_ring_buffers i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run timed out", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic uart_rb_rx_ptr_t rx_advance(input uart_rb_rx_ptr_t p);
        return RX_PTR_W'((int'(p) + 1) % RX_DEPTH);
    endfunction

    function automatic uart_rb_tx_ptr_t tx_advance(input uart_rb_tx_ptr_t p);
        return TX_PTR_W'((int'(p) + 1) % TX_DEPTH);
    endfunction

    function automatic uart_rb_out_t predict_ring_event(input uart_rb_in_t word);
        uart_rb_out_t res;
        res = '0;
        case (word.opcode)
            OP_HOST_READ: begin
                if (rx_rd != rx_wr) begin
                    res.read_byte = rx_mem[rx_rd];
                    rx_rd = rx_advance(rx_rd);
                end else begin
                    rx_rd = '0;
                    rx_wr = '0;
                end
            end
            OP_HOST_WRITE: begin
                if (tx_rd == tx_wr && word.tx_ready_flag) begin
                    res.line_byte = word.data_byte;
                    res.line_send = 1'b1;
                end else if (tx_advance(tx_wr) != tx_rd) begin
                    tx_mem[tx_wr] = word.data_byte;
                    tx_wr = tx_advance(tx_wr);
                end else begin
                    res.byte_dropped = 1'b1;
                end
                irq_en = 1'b1;
            end
            OP_LINE_RX: begin
                if (rx_advance(rx_wr) != rx_rd) begin
                    rx_mem[rx_wr] = word.data_byte;
                    rx_wr = rx_advance(rx_wr);
                end else begin
                    res.byte_dropped = 1'b1;
                end
            end
            default: begin
                if (tx_rd != tx_wr) begin
                    res.line_byte = tx_mem[tx_rd];
                    res.line_send = 1'b1;
                    tx_rd = tx_advance(tx_rd);
                end
                if (tx_rd == tx_wr) begin
                    tx_rd  = '0;
                    tx_wr  = '0;
                    irq_en = 1'b0;
                end
            end
        endcase
        res.tx_irq_enable = irq_en;
        return res;
    endfunction

    function automatic uart_rb_op_t pick_opcode(input traffic_t mode);
        uart_rb_op_t op;
        case (mode)
            TR_RX_FILL:  op = OP_LINE_RX;
            TR_RX_DRAIN: op = OP_HOST_READ;
            TR_TX_FILL:  op = OP_HOST_WRITE;
            TR_TX_DRAIN: op = OP_TX_READY;
            default:     op = uart_rb_op_t'(2'($urandom_range(0, 3)));
        endcase
        if ($urandom_range(0, 99) < 15) begin
            op = uart_rb_op_t'(2'($urandom_range(0, 3)));
        end
        return op;
    endfunction

    task automatic offer_word(input uart_rb_in_t word, input logic typed,
                              input uart_rb_out_t typed_result);
        int unsigned  gap;
        uart_rb_out_t predicted;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= word;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_ring_event(word);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %02h actual %02h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input uart_rb_out_t got);
        uart_rb_out_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: result word with none expected, actual %p", $time, got);
            mismatch_count++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("read_byte", want.read_byte, got.read_byte);
        compare_field("line_byte", want.line_byte, got.line_byte);
        compare_field("line_send", 8'(want.line_send), 8'(got.line_send));
        compare_field("tx_irq_enable", 8'(want.tx_irq_enable), 8'(got.tx_irq_enable));
        compare_field("byte_dropped", 8'(want.byte_dropped), 8'(got.byte_dropped));
    endtask

    initial begin
        int unsigned gap;
        wait (aresetn === 1'b1);
        forever begin
            if (results_seen == HOLD_AT) begin
                gap = HOLD_CYCLES;
            end else begin
                gap = $urandom_range(0, recv_gap_max);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            check_result(m_data);
            results_seen++;
        end
    end

    initial begin
        uart_rb_in_t word;
        traffic_t    mode;
        int unsigned seg_len;
        int unsigned random_sent;
        random_sent = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            word.opcode        = directed_rows[i].opcode;
            word.data_byte     = directed_rows[i].data_byte;
            word.tx_ready_flag = directed_rows[i].tx_ready_flag;
            offer_word(word, directed_rows[i].typed, directed_rows[i].result);
        end

        while (random_sent < RANDOM_ITEMS) begin
            mode         = traffic_t'($urandom_range(0, 4));
            seg_len      = $urandom_range(40, 100);
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
            recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
            for (int k = 0; k < seg_len && random_sent < RANDOM_ITEMS; k++) begin
                word.opcode        = pick_opcode(mode);
                word.data_byte     = 8'($urandom_range(0, 255));
                word.tx_ready_flag = 1'($urandom_range(0, 1));
                offer_word(word, 1'b0, '0);
                random_sent++;
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/uart_rb_pkg.sv
rtl/core/uart_rb_ram.sv
rtl/core/uart_rb_ctrl.sv
rtl/core/uart_rb_datapath.sv
rtl/core/uart_rx_tx_ring_buffers.sv
test/tb_top.sv
